>>> hw/rtl/distance_follow_drive_controller_defines.svh
// Assertion macros shared by the RTL of the distance follow drive controller.
// Each macro expects clk and arst_n in scope.
`ifndef DISTANCE_FOLLOW_DRIVE_CONTROLLER_DEFINES_SVH
`define DISTANCE_FOLLOW_DRIVE_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define DFDC_ASSERT_NOW(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error("dfdc: same-cycle check failed");

// Next-cycle implication.
`define DFDC_ASSERT_NEXT(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("dfdc: next-cycle check failed");

`endif

>>> hw/rtl/dfdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dfdc_pkg;

	localparam int PwmFullScaleDef = 10000;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 14;
	localparam int StatW    = 8;
	localparam int DistW    = 13;
	localparam int DutyW    = 14;
	localparam int IntegW   = 13;

	// Register reset values
	localparam logic [10:0] RstRefDist  = 11'd100;
	localparam logic [11:0] RstIntLim   = 12'd2000;
	localparam logic [12:0] RstSpdLim   = 13'd4000;
	localparam logic [9:0]  RstDeadband = 10'd50;
	localparam logic [13:0] RstPwmOff   = 14'd6000;
	localparam logic [10:0] RstValidMin = 11'd5;
	localparam logic [12:0] RstValidMax = 13'd500;
	localparam logic [7:0]  RstErrLim   = 8'd10;

	typedef enum logic [CfgIdxW-1:0] {
		REG_REF_DIST  = 3'd0,
		REG_INT_LIM   = 3'd1,
		REG_SPD_LIM   = 3'd2,
		REG_DEADBAND  = 3'd3,
		REG_PWM_OFF   = 3'd4,
		REG_VALID_MIN = 3'd5,
		REG_VALID_MAX = 3'd6,
		REG_ERR_LIM   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BWD  = 2'd2
	} dir_t;

	typedef struct packed {
		logic [10:0] ref_dist;
		logic [11:0] int_lim;
		logic [12:0] spd_lim;
		logic [9:0]  deadband;
		logic [13:0] pwm_off;
		logic [10:0] valid_min;
		logic [12:0] valid_max;
		logic [7:0]  err_lim;
	} cfg_t;

	typedef struct packed {
		logic             sample_ready;
		logic [StatW-1:0] right_status;
		logic [DistW-1:0] right_distance;
		logic [StatW-1:0] left_status;
		logic [DistW-1:0] left_distance;
	} item_t;

	typedef struct packed {
		logic [DutyW-1:0] left_duty;
		dir_t             left_direction;
		logic [DutyW-1:0] right_duty;
		dir_t             right_direction;
		logic             in_window;
		logic             fault;
	} res_t;

	typedef struct packed {
		logic                     fault;
		logic signed [IntegW-1:0] integral;
	} st_t;

endpackage
`default_nettype wire

>>> hw/rtl/distance_follow_drive_controller.sv
// Channel  Dir  Handshake               Payload
// s_*      in   s_tvalid / s_tready     s_tdata sensor sample, s_tuser sample_ready
// m_*      out  m_tvalid / m_tready     m_tdata wheel duties, directions, window, fault
// cfg_*    in   cfg_valid / cfg_ready   cfg_index register, cfg_data value
//
// Requests pass the input, then the result register; one per cycle unless stalled.
// The whole control tick is combinational between the input register and the result
// register, with the held ranges, counts, integral and fault fed back from the tick.
// Reset restores register defaults and clears all state; no clearing pass is needed.
// A stalled result holds in the output register while one more request waits in the
// input register; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
`include "distance_follow_drive_controller_defines.svh"
module distance_follow_drive_controller #(
	parameter int PWM_FULL_SCALE = dfdc_pkg::PwmFullScaleDef
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// [7:0] right_status, [20:8] right_distance, [28:21] left_status,
	// [41:29] left_distance, [47:42] zero
	input  wire  [47:0]                       s_tdata,
	// [0] sample_ready
	input  wire                               s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// [13:0] left_duty, [15:14] left_direction, [29:16] right_duty,
	// [31:30] right_direction, [32] in_window, [33] fault, [39:34] zero
	output logic [39:0]                       m_tdata,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [dfdc_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire  [dfdc_pkg::CfgDataW-1:0]     cfg_data
);

	dfdc_pkg::cfg_t  cfg;
	dfdc_pkg::item_t item_s1;
	dfdc_pkg::res_t  res, res_s2;
	dfdc_pkg::st_t   st;
	logic            valid_s1, valid_s2;
	logic            adv, go;

	assign cfg_ready = 1'b1;

	dfdc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv      = !valid_s2 || m_tready;
	assign go       = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.sample_ready   <= s_tuser;
			item_s1.right_status   <= s_tdata[7:0];
			item_s1.right_distance <= s_tdata[20:8];
			item_s1.left_status    <= s_tdata[28:21];
			item_s1.left_distance  <= s_tdata[41:29];
		end
		if (go)
			res_s2 <= res;
	end

	dfdc_core #(.PWM_FULL_SCALE(PWM_FULL_SCALE)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res),
		.st     (st)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, res_s2.fault, res_s2.in_window,
	                   res_s2.right_direction, res_s2.right_duty,
	                   res_s2.left_direction, res_s2.left_duty};

	// Fault is sticky and freezes the integral
	`DFDC_ASSERT_NEXT(a_fault_sticky, st.fault, st.fault)
	`DFDC_ASSERT_NEXT(a_integ_frozen, st.fault, $stable(st.integral))
	// A waiting request in the input stage is never dropped
	`DFDC_ASSERT_NEXT(a_s1_held, valid_s1 && !adv, valid_s1)
	// A new result only comes from a request in the input stage
	`DFDC_ASSERT_NOW(a_res_source, $rose(valid_s2), $past(valid_s1))

endmodule
`default_nettype wire

>>> hw/rtl/dfdc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module dfdc_cfg (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                wr_en,
	input  wire [dfdc_pkg::CfgIdxW-1:0]        wr_index,
	input  wire [dfdc_pkg::CfgDataW-1:0]       wr_data,
	output dfdc_pkg::cfg_t                     cfg
);

	dfdc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_dist  <= dfdc_pkg::RstRefDist;
			cfg_q.int_lim   <= dfdc_pkg::RstIntLim;
			cfg_q.spd_lim   <= dfdc_pkg::RstSpdLim;
			cfg_q.deadband  <= dfdc_pkg::RstDeadband;
			cfg_q.pwm_off   <= dfdc_pkg::RstPwmOff;
			cfg_q.valid_min <= dfdc_pkg::RstValidMin;
			cfg_q.valid_max <= dfdc_pkg::RstValidMax;
			cfg_q.err_lim   <= dfdc_pkg::RstErrLim;
		end else if (wr_en) begin
			unique case (dfdc_pkg::reg_idx_t'(wr_index))
				dfdc_pkg::REG_REF_DIST:  cfg_q.ref_dist  <= wr_data[10:0];
				dfdc_pkg::REG_INT_LIM:   cfg_q.int_lim   <= wr_data[11:0];
				dfdc_pkg::REG_SPD_LIM:   cfg_q.spd_lim   <= wr_data[12:0];
				dfdc_pkg::REG_DEADBAND:  cfg_q.deadband  <= wr_data[9:0];
				dfdc_pkg::REG_PWM_OFF:   cfg_q.pwm_off   <= wr_data[13:0];
				dfdc_pkg::REG_VALID_MIN: cfg_q.valid_min <= wr_data[10:0];
				dfdc_pkg::REG_VALID_MAX: cfg_q.valid_max <= wr_data[12:0];
				dfdc_pkg::REG_ERR_LIM:   cfg_q.err_lim   <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> hw/rtl/dfdc_wheel.sv
`timescale 1ns / 1ps
`default_nettype none
module dfdc_wheel #(
	parameter int PWM_FULL_SCALE = dfdc_pkg::PwmFullScaleDef
) (
	input  wire signed [13:0]               speed,
	input  wire        [9:0]                deadband,
	input  wire        [13:0]               pwm_off,
	output logic [dfdc_pkg::DutyW-1:0]      duty,
	output dfdc_pkg::dir_t                  dir,
	output logic                            ovf
);

	localparam int FsW  = $clog2(PWM_FULL_SCALE + 1);
	localparam int CmpW = (FsW > 15) ? FsW : 15;

	logic [13:0] neg;
	logic [12:0] mag;
	logic        stop;
	logic [14:0] sum;

	always_comb begin
		neg  = 14'(-speed);
		mag  = speed[13] ? neg[12:0] : speed[12:0];
		stop = mag <= {3'b0, deadband};
		sum  = {2'b0, mag} + {1'b0, pwm_off};
		ovf  = !stop && (CmpW'(sum) > CmpW'(PWM_FULL_SCALE));
		if (stop) begin
			duty = '0;
			dir  = dfdc_pkg::DIR_STOP;
		end else begin
			duty = sum[dfdc_pkg::DutyW-1:0];
			dir  = speed[13] ? dfdc_pkg::DIR_BWD : dfdc_pkg::DIR_FWD;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/dfdc_core.sv
`timescale 1ns / 1ps
`default_nettype none
module dfdc_core #(
	parameter int PWM_FULL_SCALE = dfdc_pkg::PwmFullScaleDef
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             go,
	input  dfdc_pkg::item_t item,
	input  dfdc_pkg::cfg_t  cfg,
	output dfdc_pkg::res_t  res,
	output dfdc_pkg::st_t   st
);

	logic        [12:0] held_r_q, held_l_q;
	logic signed [12:0] integ_q;
	logic        [7:0]  cnt_r_q, cnt_l_q;
	logic               fault_q;

	logic               upd, r_ok, l_ok, cnt_fault, run, ovl, ovr, fault_n;
	logic        [12:0] held_r_n, held_l_n;
	logic        [7:0]  cnt_r_n, cnt_l_n;
	logic        [13:0] pair_sum;
	logic        [12:0] mean;
	logic signed [15:0] sum_i, lim16;
	logic signed [15:0] int_c;
	logic signed [12:0] integ_n;
	logic signed [14:0] x3, x3r, base;
	logic signed [13:0] diff;
	logic signed [16:0] turn, ls_raw, rs_raw, slim17, ls_c, rs_c;
	logic signed [13:0] ls, rs;
	logic [dfdc_pkg::DutyW-1:0] ld, rd;
	dfdc_pkg::dir_t     ldir, rdir;

	always_comb begin
		upd  = !fault_q && item.sample_ready;
		r_ok = item.right_status == '0;
		l_ok = item.left_status == '0;

		cnt_r_n  = cnt_r_q;
		held_r_n = held_r_q;
		cnt_l_n  = cnt_l_q;
		held_l_n = held_l_q;
		if (upd) begin
			if (r_ok) begin
				held_r_n = item.right_distance;
				cnt_r_n  = '0;
			end else if (cnt_r_q != 8'hFF) begin
				cnt_r_n = cnt_r_q + 8'd1;
			end
			if (l_ok) begin
				held_l_n = item.left_distance;
				cnt_l_n  = '0;
			end else if (cnt_l_q != 8'hFF) begin
				cnt_l_n = cnt_l_q + 8'd1;
			end
		end
		cnt_fault = upd && ((cnt_l_n > cfg.err_lim) || (cnt_r_n > cfg.err_lim));
		run       = !fault_q && !cnt_fault;

		// Integral loop on the mean range
		pair_sum = {1'b0, held_l_n} + {1'b0, held_r_n};
		mean     = pair_sum[13:1];
		sum_i    = 16'(integ_q) + signed'({5'b0, cfg.ref_dist}) - signed'({3'b0, mean});
		lim16    = signed'({4'b0, cfg.int_lim});
		if (sum_i > lim16)
			int_c = lim16;
		else if (sum_i < -lim16)
			int_c = -lim16;
		else
			int_c = sum_i;
		integ_n = int_c[12:0];

		// 1.5 * integral, rounded toward zero
		x3   = (15'(integ_n) <<< 1) + 15'(integ_n);
		x3r  = x3 + signed'({14'b0, x3[14]});
		base = x3r >>> 1;

		diff   = signed'({1'b0, held_l_n}) - signed'({1'b0, held_r_n});
		turn   = 17'(diff) <<< 1;
		ls_raw = 17'(base) - turn;
		rs_raw = 17'(base) + turn;
		slim17 = signed'({4'b0, cfg.spd_lim});
		if (ls_raw > slim17)
			ls_c = slim17;
		else if (ls_raw < -slim17)
			ls_c = -slim17;
		else
			ls_c = ls_raw;
		if (rs_raw > slim17)
			rs_c = slim17;
		else if (rs_raw < -slim17)
			rs_c = -slim17;
		else
			rs_c = rs_raw;
		ls = ls_c[13:0];
		rs = rs_c[13:0];
	end

	dfdc_wheel #(.PWM_FULL_SCALE(PWM_FULL_SCALE)) u_wheel_l (
		.speed    (ls),
		.deadband (cfg.deadband),
		.pwm_off  (cfg.pwm_off),
		.duty     (ld),
		.dir      (ldir),
		.ovf      (ovl)
	);

	dfdc_wheel #(.PWM_FULL_SCALE(PWM_FULL_SCALE)) u_wheel_r (
		.speed    (rs),
		.deadband (cfg.deadband),
		.pwm_off  (cfg.pwm_off),
		.duty     (rd),
		.dir      (rdir),
		.ovf      (ovr)
	);

	always_comb begin
		fault_n = fault_q || cnt_fault || (run && (ovl || ovr));
		if (fault_n) begin
			res.left_duty       = '0;
			res.left_direction  = dfdc_pkg::DIR_STOP;
			res.right_duty      = '0;
			res.right_direction = dfdc_pkg::DIR_STOP;
		end else begin
			res.left_duty       = ld;
			res.left_direction  = ldir;
			res.right_duty      = rd;
			res.right_direction = rdir;
		end
		res.in_window = (held_r_n > {2'b0, cfg.valid_min}) && (held_r_n <= cfg.valid_max) &&
		                (held_l_n > {2'b0, cfg.valid_min}) && (held_l_n <= cfg.valid_max);
		res.fault     = fault_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_r_q <= '0;
			held_l_q <= '0;
			integ_q  <= '0;
			cnt_r_q  <= '0;
			cnt_l_q  <= '0;
			fault_q  <= 1'b0;
		end else if (go) begin
			held_r_q <= held_r_n;
			held_l_q <= held_l_n;
			cnt_r_q  <= cnt_r_n;
			cnt_l_q  <= cnt_l_n;
			fault_q  <= fault_n;
			if (run)
				integ_q <= integ_n;
		end
	end

	assign st.fault    = fault_q;
	assign st.integral = integ_q;

endmodule
`default_nettype wire
